@@ hw/rtl/motor_link_request_scheduler_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Motor link request scheduler assertion macros
// Shared concurrent-check forms used by the scheduler modules.
// ----------------------------------------------------------------------------
`ifndef MOTOR_LINK_REQUEST_SCHEDULER_UNIT_ASSERT_SVH
`define MOTOR_LINK_REQUEST_SCHEDULER_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define MLRS_ASSERT_ALWAYS(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("scheduler check failed");

// Check that an antecedent implies a consequent in the same cycle
`define MLRS_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("scheduler check failed");

`endif

@@ hw/rtl/mlrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor link request scheduler package
// Types, register addresses and codes shared by the scheduler modules.
// ----------------------------------------------------------------------------
package mlrs_pkg;

    // Mask and channel field widths are fixed by the item format
    localparam int LANES = 4;

    // Queue between front and back end
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // Drive register addresses
    localparam logic [15:0] REG_SPEED   = 16'h2001;
    localparam logic [15:0] REG_CMD     = 16'h2000;
    localparam logic [15:0] REG_CURRENT = 16'h3004;
    localparam logic [15:0] REG_HALL    = 16'h3013;

    // Command words and read lengths
    localparam logic [15:0] CMD_WORD_FWD  = 16'h0001;
    localparam logic [15:0] CMD_WORD_REV  = 16'h0002;
    localparam logic [15:0] CMD_WORD_STOP = 16'h0009;
    localparam logic [15:0] WORDS_CURRENT = 16'h0001;
    localparam logic [15:0] WORDS_HALL    = 16'h0002;

    localparam logic [7:0] SAT_MAX     = 8'd255;
    localparam logic [7:0] POLL_RESET  = 8'd10;

    typedef enum logic [1:0] {
        KIND_CTRL = 2'd0,
        KIND_TICK = 2'd1,
        KIND_DONE = 2'd2,
        KIND_NONE = 2'd3
    } item_kind_t;

    typedef enum logic [1:0] {
        CMD_SPEED = 2'd0,
        CMD_FWD   = 2'd1,
        CMD_REV   = 2'd2,
        CMD_HALT  = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        DONE_CMD     = 2'd0,
        DONE_SPEED   = 2'd1,
        DONE_HALL    = 2'd2,
        DONE_CURRENT = 2'd3
    } done_op_t;

    typedef enum logic {
        RES_REQUEST = 1'b0,
        RES_STATUS  = 1'b1
    } result_kind_t;

    // Classified item as it waits in the queue
    typedef struct packed {
        item_kind_t         kind;
        logic [LANES-1:0]   mask;
        cmd_code_t          cmd_code;
        logic signed [15:0] speed;
        logic [1:0]         channel;
        done_op_t           done_op;
        logic               success;
        logic [15:0]        data_high;
        logic [15:0]        data_low;
    } mlrs_item_t;

    // One result beat
    typedef struct packed {
        result_kind_t       result_kind;
        logic [1:0]         out_channel;
        logic               is_write;
        logic [15:0]        reg_addr;
        logic [15:0]        reg_value;
        logic               last;
        logic [7:0]         retry_count;
        logic [7:0]         comm_errors;
        logic [31:0]        hall_position;
        logic [15:0]        current_centiamps;
        logic signed [15:0] applied_speed;
        logic [1:0]         applied_command;
    } mlrs_result_t;

    // Queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } mlrs_qstat_t;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == SAT_MAX) ? v : v + 8'd1;
    endfunction

endpackage

@@ hw/rtl/mlrs_queue.sv @@
// ----------------------------------------------------------------------------
// Motor link request scheduler item queue
// Short FIFO of classified items between the front and back end.
// ----------------------------------------------------------------------------
module mlrs_queue
    import mlrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  mlrs_item_t  push_item,
    input  logic        pop,
    output mlrs_item_t  head,
    output mlrs_qstat_t stat
);

    mlrs_item_t     entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (QAW+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);

`include "motor_link_request_scheduler_unit_assert.svh"

    `MLRS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= (QAW+1)'(QDEPTH))
    `MLRS_ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !stat.full)
    `MLRS_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, !stat.empty)

endmodule

@@ hw/rtl/mlrs_front.sv @@
// ----------------------------------------------------------------------------
// Motor link request scheduler front end
// Accepts input beats, classifies them and drops those with no effect.
// ----------------------------------------------------------------------------
module mlrs_front
    import mlrs_pkg::*;
#(
    parameter int CHANNELS = 4
)
(
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         kind,
    input  logic [3:0]         sel_mask,
    input  logic [1:0]         cmd_code,
    input  logic signed [15:0] speed_req,
    input  logic [3:0]         idle_mask,
    input  logic [1:0]         channel,
    input  logic [1:0]         done_op,
    input  logic               success,
    input  logic [15:0]        data_high,
    input  logic [15:0]        data_low,
    input  mlrs_qstat_t        qstat,
    output logic               push,
    output mlrs_item_t         push_item
);

    localparam int NCH = (CHANNELS < LANES) ? CHANNELS : LANES;
    localparam logic [LANES-1:0] CH_MASK = LANES'((1 << NCH) - 1);

    logic keep;

    // Classify the beat and mask off channels that do not exist
    always_comb
    begin
        push_item           = '0;
        push_item.cmd_code  = cmd_code_t'(cmd_code);
        push_item.speed     = speed_req;
        push_item.channel   = channel;
        push_item.done_op   = done_op_t'(done_op);
        push_item.success   = success;
        push_item.data_high = data_high;
        push_item.data_low  = data_low;
        keep                = 1'b0;
        unique case (kind)
            KIND_CTRL:
            begin
                push_item.kind = KIND_CTRL;
                push_item.mask = sel_mask & CH_MASK;
                keep           = |push_item.mask;
            end
            KIND_TICK:
            begin
                push_item.kind = KIND_TICK;
                push_item.mask = idle_mask & CH_MASK;
                keep           = |push_item.mask;
            end
            KIND_DONE:
            begin
                push_item.kind = KIND_DONE;
                keep           = (int'(channel) < NCH);
            end
            default:
            begin
                push_item.kind = KIND_NONE;
                keep           = 1'b0;
            end
        endcase
    end

    assign item_ready = !qstat.full;
    assign push       = item_valid && item_ready && keep;

endmodule

@@ hw/rtl/mlrs_back.sv @@
// ----------------------------------------------------------------------------
// Motor link request scheduler back end
// Holds per-channel state, retires queued items and drives the result register.
// ----------------------------------------------------------------------------
module mlrs_back
    import mlrs_pkg::*;
#(
    parameter int CHANNELS = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    input  mlrs_item_t   head,
    input  mlrs_qstat_t  qstat,
    output logic         pop,
    output logic         result_valid,
    input  logic         result_ready,
    output mlrs_result_t result
);

    localparam int NCH = (CHANNELS < LANES) ? CHANNELS : LANES;
    localparam int IW  = (NCH > 1) ? $clog2(NCH) : 1;

    // Per-channel state
    logic [15:0] pend_speed_val_reg [NCH];
    logic        pend_speed_flag_reg [NCH];
    logic [1:0]  pend_cmd_val_reg [NCH];
    logic        pend_cmd_flag_reg [NCH];
    logic [7:0]  poll_counter_reg [NCH];
    logic [15:0] issued_speed_reg [NCH];
    logic [1:0]  issued_cmd_reg [NCH];
    logic [15:0] acked_speed_reg [NCH];
    logic [1:0]  acked_cmd_reg [NCH];
    logic [7:0]  retry_reg [NCH];
    logic [7:0]  error_reg [NCH];
    logic [31:0] hall_reg [NCH];
    logic [15:0] current_reg [NCH];

    logic [7:0]       poll_interval_reg;
    logic             tick_active_reg, tick_active_next;
    logic [LANES-1:0] tick_mask_reg, tick_mask_next;
    logic             result_valid_reg, result_valid_next;
    mlrs_result_t     result_reg, result_next;

    logic             head_valid, out_free, go;
    logic             tick_we, done_we;
    logic [LANES-1:0] cur_mask, rest;
    logic [1:0]       sel_ch, ch_sel;
    logic [IW-1:0]    idx;

    logic [15:0] rd_pspeed;
    logic        rd_pspeed_flag;
    logic [1:0]  rd_pcmd;
    logic        rd_pcmd_flag;
    logic [7:0]  rd_poll;

    logic        req_write;
    logic [15:0] req_addr, req_value;
    logic [7:0]  cnt_inc, poll_next;

    logic [7:0]  new_retry, new_err;
    logic [31:0] new_hall;
    logic [15:0] new_cur, new_aspeed;
    logic [1:0]  new_acmd;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_interval_reg <= POLL_RESET;
        end
        else if (cfg_we)
        begin
            poll_interval_reg <= cfg_wdata;
        end
    end

    // Pick the next channel of a frame tick: lowest remaining idle bit
    assign head_valid = !qstat.empty;
    assign cur_mask   = tick_active_reg ? tick_mask_reg : head.mask;

    always_comb
    begin
        priority if (cur_mask[0])
        begin
            sel_ch = 2'd0;
        end
        else if (cur_mask[1])
        begin
            sel_ch = 2'd1;
        end
        else if (cur_mask[2])
        begin
            sel_ch = 2'd2;
        end
        else
        begin
            sel_ch = 2'd3;
        end
    end

    assign rest     = cur_mask & ~(LANES'(1) << sel_ch);
    assign ch_sel   = (head.kind == KIND_DONE) ? head.channel : sel_ch;
    assign idx      = ch_sel[IW-1:0];
    assign out_free = !result_valid_reg || result_ready;
    assign go       = head_valid && ((head.kind == KIND_CTRL) || out_free);
    assign tick_we  = go && (head.kind == KIND_TICK);
    assign done_we  = go && (head.kind == KIND_DONE);
    assign pop      = go && ((head.kind != KIND_TICK) || (rest == '0));

    // Read the selected channel
    assign rd_pspeed      = pend_speed_val_reg[idx];
    assign rd_pspeed_flag = pend_speed_flag_reg[idx];
    assign rd_pcmd        = pend_cmd_val_reg[idx];
    assign rd_pcmd_flag   = pend_cmd_flag_reg[idx];
    assign rd_poll        = poll_counter_reg[idx];

    // Choose the request: speed write, command write, current poll, hall read
    always_comb
    begin
        cnt_inc   = sat_inc8(rd_poll);
        poll_next = rd_poll;
        req_write = 1'b0;
        req_addr  = REG_HALL;
        req_value = WORDS_HALL;
        if (rd_pspeed_flag)
        begin
            req_write = 1'b1;
            req_addr  = REG_SPEED;
            req_value = rd_pspeed;
        end
        else if (rd_pcmd_flag)
        begin
            req_write = 1'b1;
            req_addr  = REG_CMD;
            if (rd_pcmd == CMD_FWD)
            begin
                req_value = CMD_WORD_FWD;
            end
            else if (rd_pcmd == CMD_REV)
            begin
                req_value = CMD_WORD_REV;
            end
            else
            begin
                req_value = CMD_WORD_STOP;
            end
        end
        else if (cnt_inc >= poll_interval_reg)
        begin
            req_addr  = REG_CURRENT;
            req_value = WORDS_CURRENT;
            poll_next = '0;
        end
        else
        begin
            poll_next = cnt_inc;
        end
    end

    // Fold a completion into the channel status
    always_comb
    begin
        new_retry  = retry_reg[idx];
        new_err    = error_reg[idx];
        new_hall   = hall_reg[idx];
        new_cur    = current_reg[idx];
        new_aspeed = acked_speed_reg[idx];
        new_acmd   = acked_cmd_reg[idx];
        unique case (head.done_op)
            DONE_CMD:
            begin
                if (head.success)
                begin
                    new_acmd  = issued_cmd_reg[idx];
                    new_retry = '0;
                end
                else
                begin
                    new_retry = sat_inc8(retry_reg[idx]);
                end
            end
            DONE_SPEED:
            begin
                if (head.success)
                begin
                    new_aspeed = issued_speed_reg[idx];
                    new_retry  = '0;
                end
                else
                begin
                    new_retry = sat_inc8(retry_reg[idx]);
                end
            end
            DONE_HALL:
            begin
                if (head.success)
                begin
                    new_hall = {head.data_high, head.data_low};
                    new_err  = '0;
                end
                else
                begin
                    new_err = sat_inc8(error_reg[idx]);
                end
            end
            DONE_CURRENT:
            begin
                if (head.success)
                begin
                    new_cur = head.data_high;
                    new_err = '0;
                end
                else
                begin
                    new_err = sat_inc8(error_reg[idx]);
                end
            end
            default:
            begin
                new_err = error_reg[idx];
            end
        endcase
    end

    // Build the next result beat and tick progress
    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        tick_active_next  = tick_active_reg;
        tick_mask_next    = tick_mask_reg;
        if (tick_we)
        begin
            result_next             = '0;
            result_next.result_kind = RES_REQUEST;
            result_next.out_channel = ch_sel;
            result_next.is_write    = req_write;
            result_next.reg_addr    = req_addr;
            result_next.reg_value   = req_value;
            result_next.last        = (rest == '0);
            result_valid_next       = 1'b1;
            tick_active_next        = (rest != '0);
            tick_mask_next          = rest;
        end
        else if (done_we)
        begin
            result_next                   = '0;
            result_next.result_kind       = RES_STATUS;
            result_next.out_channel       = ch_sel;
            result_next.last              = 1'b1;
            result_next.retry_count       = new_retry;
            result_next.comm_errors       = new_err;
            result_next.hall_position     = new_hall;
            result_next.current_centiamps = new_cur;
            result_next.applied_speed     = new_aspeed;
            result_next.applied_command   = new_acmd;
            result_valid_next             = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_active_reg  <= 1'b0;
            tick_mask_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            tick_active_reg  <= tick_active_next;
            tick_mask_reg    <= tick_mask_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Update per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                pend_speed_val_reg[i]  <= '0;
                pend_speed_flag_reg[i] <= 1'b0;
                pend_cmd_val_reg[i]    <= '0;
                pend_cmd_flag_reg[i]   <= 1'b0;
                poll_counter_reg[i]    <= '0;
                issued_speed_reg[i]    <= '0;
                issued_cmd_reg[i]      <= '0;
                acked_speed_reg[i]     <= '0;
                acked_cmd_reg[i]       <= '0;
                retry_reg[i]           <= '0;
                error_reg[i]           <= '0;
                hall_reg[i]            <= '0;
                current_reg[i]         <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NCH; i++)
            begin
                // Control message: overwrite the pending slot
                if (go && (head.kind == KIND_CTRL) && head.mask[i])
                begin
                    if (head.cmd_code == CMD_SPEED)
                    begin
                        pend_speed_val_reg[i]  <= head.speed;
                        pend_speed_flag_reg[i] <= 1'b1;
                    end
                    else
                    begin
                        pend_cmd_val_reg[i]  <= head.cmd_code;
                        pend_cmd_flag_reg[i] <= 1'b1;
                    end
                end
                // Frame tick: retire the pending write or advance the poll count
                if (tick_we && (idx == IW'(i)))
                begin
                    if (pend_speed_flag_reg[i])
                    begin
                        issued_speed_reg[i]    <= pend_speed_val_reg[i];
                        pend_speed_flag_reg[i] <= 1'b0;
                    end
                    else if (pend_cmd_flag_reg[i])
                    begin
                        issued_cmd_reg[i]    <= pend_cmd_val_reg[i];
                        pend_cmd_flag_reg[i] <= 1'b0;
                    end
                    else
                    begin
                        poll_counter_reg[i] <= poll_next;
                    end
                end
                // Completion: store the folded status
                if (done_we && (idx == IW'(i)))
                begin
                    retry_reg[i]       <= new_retry;
                    error_reg[i]       <= new_err;
                    hall_reg[i]        <= new_hall;
                    current_reg[i]     <= new_cur;
                    acked_speed_reg[i] <= new_aspeed;
                    acked_cmd_reg[i]   <= new_acmd;
                end
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`include "motor_link_request_scheduler_unit_assert.svh"

    `MLRS_ASSERT_IMPLY(a_tick_mask_live, clk, rst_n, tick_active_reg, tick_mask_reg != '0)
    `MLRS_ASSERT_IMPLY(a_tick_holds_head, clk, rst_n, tick_active_reg, head_valid)
    `MLRS_ASSERT_IMPLY(a_status_last, clk, rst_n,
        result_valid_reg && (result_reg.result_kind == RES_STATUS), result_reg.last)
    `MLRS_ASSERT_IMPLY(a_channel_range, clk, rst_n, result_valid_reg,
        int'(result_reg.out_channel) < NCH)

endmodule

@@ hw/rtl/motor_link_request_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// Motor link request scheduler
// Per-channel drive register request scheduling and completion status.
// ----------------------------------------------------------------------------
// Input beats are accepted one per cycle while the two-entry item queue has
// room, also while a result waits in the output register. The back end
// retires a control message, a completion as one status beat and a frame
// tick as one request beat per idle channel, so one to four request beats;
// its single channel-state read port visits one channel per cycle while
// the output register is free. Beats of kind three, control messages and
// ticks that select no existing channel, and completions on a channel
// beyond CHANNELS are dropped at the front and give no result.
module motor_link_request_scheduler_unit
    import mlrs_pkg::*;
#(
    parameter int CHANNELS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         kind,
    input  logic [3:0]         sel_mask,
    input  logic [1:0]         cmd_code,
    input  logic signed [15:0] speed_req,
    input  logic [3:0]         idle_mask,
    input  logic [1:0]         channel,
    input  logic [1:0]         done_op,
    input  logic               success,
    input  logic [15:0]        data_high,
    input  logic [15:0]        data_low,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               result_kind,
    output logic [1:0]         out_channel,
    output logic               is_write,
    output logic [15:0]        reg_addr,
    output logic [15:0]        reg_value,
    output logic               last,
    output logic [7:0]         retry_count,
    output logic [7:0]         comm_errors,
    output logic [31:0]        hall_position,
    output logic [15:0]        current_centiamps,
    output logic signed [15:0] applied_speed,
    output logic [1:0]         applied_command
);

    mlrs_item_t   push_item, head;
    mlrs_qstat_t  qstat;
    mlrs_result_t result;
    logic         push, pop;

    // Accept and classify
    mlrs_front #(
        .CHANNELS(CHANNELS)
    ) u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .kind       (kind),
        .sel_mask   (sel_mask),
        .cmd_code   (cmd_code),
        .speed_req  (speed_req),
        .idle_mask  (idle_mask),
        .channel    (channel),
        .done_op    (done_op),
        .success    (success),
        .data_high  (data_high),
        .data_low   (data_low),
        .qstat      (qstat),
        .push       (push),
        .push_item  (push_item)
    );

    // Decouple front and back
    mlrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    // Carry out items
    mlrs_back #(
        .CHANNELS(CHANNELS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Break out the result beat
    assign result_kind       = result.result_kind;
    assign out_channel       = result.out_channel;
    assign is_write          = result.is_write;
    assign reg_addr          = result.reg_addr;
    assign reg_value         = result.reg_value;
    assign last              = result.last;
    assign retry_count       = result.retry_count;
    assign comm_errors       = result.comm_errors;
    assign hall_position     = result.hall_position;
    assign current_centiamps = result.current_centiamps;
    assign applied_speed     = result.applied_speed;
    assign applied_command   = result.applied_command;

endmodule
